FILE: rtl/core/msld_pkg.sv
// shared constants for the multi-slot limit switch debounce block
package msld_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int MASK_W      = 8;
  localparam int TIME_W      = 16;
  localparam int PHASE_W     = 2;
  localparam int DATA_W      = 3 * MASK_W;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 4;

  localparam logic [PHASE_W-1:0] PH_CLOSED      = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT_IDLE   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT_ACTIVE = 2'd2;

  localparam logic [1:0] REG_ACTIVE_LEVELS  = 2'd0;
  localparam logic [1:0] REG_REVERSE_MASK   = 2'd1;
  localparam logic [1:0] REG_TICK_PERIOD_US = 2'd2;
  localparam logic [1:0] REG_STABLE_TIME_US = 2'd3;

  localparam logic [TIME_W-1:0] TICK_PERIOD_RST = 16'd100;
  localparam logic [TIME_W-1:0] STABLE_TIME_RST = 16'd1000;
  localparam logic [TIME_W-1:0] TIME_MAX        = 16'hFFFF;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  stable;
  } slot_t;

endpackage

FILE: rtl/core/multi_slot_limit_debounce.sv
// multi-slot limit switch debounce: top level with per-slot state memory
// One input item is one scan-timer tick; it yields one result item. The slot
// states live in a single-port-per-direction memory, and each tick sweeps the
// slots one per cycle (read, debounce, write back), save for the final-slot
// hold below; the next tick is accepted in the cycle the last slot is written
// back, so a tick is not taken before the previous sweep is through. A
// result waits in the output register without blocking the next tick's sweep,
// except that the final slot of a sweep holds while a previous result is still
// untaken. No clearing pass is needed after reset.
module multi_slot_limit_debounce #(
  parameter int SLOTS = msld_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_axis_tdata: pin_levels, open_requests, close_requests
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [msld_pkg::DATA_W-1:0]    s_axis_tdata,
  // m_axis_tdata: trigger_mask, armed_mask, waiting_mask
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [msld_pkg::DATA_W-1:0]    m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msld_pkg::APB_AW-1:0]    paddr,
  input  logic [msld_pkg::APB_DW-1:0]    pwdata,
  output logic [msld_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import msld_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // configuration registers
  logic [MASK_W-1:0] active_levels;
  logic [MASK_W-1:0] reverse_mask;
  logic [TIME_W-1:0] tick_period_us;
  logic [TIME_W-1:0] stable_time_us;

  // current tick
  logic [MASK_W-1:0] pin_levels;
  logic [MASK_W-1:0] open_requests;
  logic [MASK_W-1:0] close_requests;

  // state memory
  slot_t             mem [SLOTS];
  logic [SLOTS-1:0]  mem_vld;
  slot_t             rdata;
  logic              rdata_vld;

  logic              rd_act;
  logic [IDX_W-1:0]  rd_idx;
  logic              b_vld;
  logic [IDX_W-1:0]  b_idx;
  logic              b_last;
  logic              adv;
  logic              accept;

  logic [SLOTS-1:0]  trig_acc, armed_acc, wait_acc;
  logic [SLOTS-1:0]  trig_next, armed_next, wait_next;

  logic              out_vld;
  logic [MASK_W-1:0] out_trig, out_armed, out_wait;

  // per-slot views of the masks
  logic [SLOTS-1:0]  pin_w, open_w, close_w, act_w, rev_w;
  slot_t             cur;
  slot_t             upd;
  logic              at_active;
  logic              fire;
  logic [TIME_W:0]   sum;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_ACTIVE_LEVELS:  prdata = APB_DW'(active_levels);
      REG_REVERSE_MASK:   prdata = APB_DW'(reverse_mask);
      REG_TICK_PERIOD_US: prdata = APB_DW'(tick_period_us);
      REG_STABLE_TIME_US: prdata = APB_DW'(stable_time_us);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_levels  <= '0;
      reverse_mask   <= '0;
      tick_period_us <= TICK_PERIOD_RST;
      stable_time_us <= STABLE_TIME_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ACTIVE_LEVELS:  active_levels  <= pwdata[MASK_W-1:0];
        REG_REVERSE_MASK:   reverse_mask   <= pwdata[MASK_W-1:0];
        REG_TICK_PERIOD_US: tick_period_us <= pwdata[TIME_W-1:0];
        REG_STABLE_TIME_US: stable_time_us <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign b_last        = (b_idx == LAST_IDX);
  assign adv           = !(b_vld && b_last && out_vld && !m_axis_tready);
  assign s_axis_tready = !rd_act && (!b_vld || (b_last && adv));
  assign accept        = s_axis_tvalid && s_axis_tready;

  // sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_act <= 1'b0;
      rd_idx <= '0;
      b_vld  <= 1'b0;
      b_idx  <= '0;
    end else begin
      if (accept) begin
        rd_act <= 1'b1;
        rd_idx <= '0;
      end else if (rd_act) begin
        if (rd_idx == LAST_IDX) begin
          rd_act <= 1'b0;
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end
      if (adv) begin
        b_vld <= rd_act;
        b_idx <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin_levels     <= s_axis_tdata[MASK_W-1:0];
      open_requests  <= s_axis_tdata[2*MASK_W-1:MASK_W];
      close_requests <= s_axis_tdata[3*MASK_W-1:2*MASK_W];
    end
  end

  // memory read port
  always_ff @(posedge clk) begin
    if (rd_act) begin
      rdata     <= mem[rd_idx];
      rdata_vld <= mem_vld[rd_idx];
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (b_vld && adv) begin
      mem[b_idx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (b_vld && adv) begin
      mem_vld[b_idx] <= 1'b1;
    end
  end

  // debounce of one slot
  always_comb begin
    pin_w   = SLOTS'(pin_levels);
    open_w  = SLOTS'(open_requests);
    close_w = SLOTS'(close_requests);
    act_w   = SLOTS'(active_levels);
    rev_w   = SLOTS'(reverse_mask);

    cur       = rdata_vld ? rdata : '0;
    upd       = cur;
    fire      = 1'b0;
    sum       = '0;
    at_active = (pin_w[b_idx] == act_w[b_idx]);

    if (open_w[b_idx]) begin
      upd.stable = '0;
      upd.phase  = (at_active ^ rev_w[b_idx]) ? PH_WAIT_ACTIVE : PH_WAIT_IDLE;
    end
    if (close_w[b_idx]) begin
      upd.phase  = PH_CLOSED;
      upd.stable = '0;
    end

    if (upd.phase == PH_WAIT_IDLE || upd.phase == PH_WAIT_ACTIVE) begin
      if (at_active == (upd.phase == PH_WAIT_ACTIVE)) begin
        sum        = {1'b0, upd.stable} + {1'b0, tick_period_us};
        upd.stable = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      end else begin
        upd.stable = '0;
      end
      if (upd.stable >= stable_time_us) begin
        upd.stable = '0;
        if (upd.phase == PH_WAIT_IDLE) begin
          upd.phase = PH_WAIT_ACTIVE;
        end else begin
          upd.phase = PH_CLOSED;
          fire      = 1'b1;
        end
      end
    end else begin
      upd.phase = PH_CLOSED;
    end

    trig_next  = (b_idx == '0) ? '0 : trig_acc;
    armed_next = (b_idx == '0) ? '0 : armed_acc;
    wait_next  = (b_idx == '0) ? '0 : wait_acc;
    trig_next[b_idx]  = fire;
    armed_next[b_idx] = (upd.phase != PH_CLOSED);
    wait_next[b_idx]  = (upd.phase == PH_WAIT_ACTIVE);
  end

  always_ff @(posedge clk) begin
    if (b_vld && adv) begin
      trig_acc  <= trig_next;
      armed_acc <= armed_next;
      wait_acc  <= wait_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (b_vld && b_last && adv) begin
      out_vld <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld && b_last && adv) begin
      out_trig  <= MASK_W'(trig_next);
      out_armed <= MASK_W'(armed_next);
      out_wait  <= MASK_W'(wait_next);
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {out_wait, out_armed, out_trig};

endmodule
